/* sv/crt_pkg.sv */
// shared widths, register indexes and types of the coefficient rejection test
package crt_pkg;

    localparam int ZW  = 16;          // coefficient width
    localparam int RW  = 24;          // random word width
    localparam int GW  = 14;          // gamma bound width
    localparam int BW  = 13;          // beta margin width
    localparam int MW  = ZW + 1;      // magnitude of a coefficient
    localparam int SW  = 19;          // signed width of the f and g terms
    localparam int PW  = RW + SW - 1; // product width
    localparam int IW  = 2;           // config index width
    localparam int CDW = 16;          // config data width

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    typedef logic [IW-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_GAMMA_BOUND = 2'd0;
    localparam cfg_idx_t REG_BETA_MARGIN = 2'd1;

    localparam logic [GW-1:0] GAMMA_RESET = 14'd2048;
    localparam logic [BW-1:0] BETA_RESET  = 13'd1;

    typedef struct packed {
        logic used;
        logic reject;
    } crt_verdict_t;

endpackage

/* sv/crt_verdict.sv */
// per-coefficient verdict: window test, f and g terms, random word compare
module crt_verdict (
    input  logic signed [crt_pkg::ZW-1:0] z_coeff,
    input  logic signed [crt_pkg::ZW-1:0] v_coeff,
    input  logic        [crt_pkg::RW-1:0] random_word,
    input  logic        [crt_pkg::GW-1:0] gamma_bound,
    input  logic        [crt_pkg::BW-1:0] beta_margin,
    output crt_pkg::crt_verdict_t         verdict
);

    localparam int MW = crt_pkg::MW;
    localparam int SW = crt_pkg::SW;
    localparam int PW = crt_pkg::PW;
    localparam int RW = crt_pkg::RW;

    logic signed [MW-1:0] zx, vx;
    logic        [MW-1:0] val, bm, beta_x, mx_vb, mx_vbeta, diff;
    logic        [MW:0]   sum_vb;
    logic signed [SW-1:0] gs, bs, lim;
    logic signed [SW-1:0] lo_f, lo_g, t1, t2, t1c, t2c, hi_f, tg, hi_g;
    logic signed [SW-1:0] f, g, f_neg_v, g_neg_v;
    logic        [SW-2:0] f_mag, g_mag;
    logic        [PW-1:0] lhs, rhs;
    logic                 fast, outright, below, f_neg, g_neg, lhs_neg, slow_rej;

    always_comb begin
        zx  = {z_coeff[crt_pkg::ZW-1], z_coeff};
        vx  = {v_coeff[crt_pkg::ZW-1], v_coeff};
        // -32768 lands on 32768 as unsigned
        val = zx[MW-1] ? MW'(-zx) : MW'(zx);
        bm  = vx[MW-1] ? MW'(-vx) : MW'(vx);

        gs     = $signed({{(SW-crt_pkg::GW){1'b0}}, gamma_bound});
        bs     = $signed({{(SW-crt_pkg::BW){1'b0}}, beta_margin});
        beta_x = {{(MW-crt_pkg::BW){1'b0}}, beta_margin};

        lim      = gs - bs;
        below    = val < beta_x;
        fast     = !below && ($signed({2'b00, val}) < lim);
        outright = val >= {{(MW-crt_pkg::GW){1'b0}}, gamma_bound};

        mx_vb    = (val > bm) ? val : bm;
        mx_vbeta = (val > beta_x) ? val : beta_x;

        // case val below beta
        lo_f = (gs - $signed({2'b00, mx_vb})) <<< 1;
        lo_g = (gs - bs) <<< 1;

        // case val at or above beta
        diff   = (val >= bm) ? val - bm : bm - val;
        sum_vb = {1'b0, val} + {1'b0, bm};
        t1     = gs - $signed({2'b00, diff});
        t2     = gs - $signed({1'b0, sum_vb});
        t1c    = t1[SW-1] ? '0 : t1;
        t2c    = t2[SW-1] ? '0 : t2;
        hi_f   = t1c + t2c;
        tg     = gs - $signed({2'b00, mx_vbeta});
        hi_g   = tg[SW-1] ? '0 : (tg <<< 1);

        f = below ? lo_f : hi_f;
        g = below ? lo_g : hi_g;

        // negative terms wrap modulo 2^64: compare sign then magnitude
        f_neg   = f[SW-1];
        g_neg   = g[SW-1];
        f_neg_v = -f;
        g_neg_v = -g;
        f_mag   = f_neg ? f_neg_v[SW-2:0] : f[SW-2:0];
        g_mag   = g_neg ? g_neg_v[SW-2:0] : g[SW-2:0];

        lhs     = PW'(random_word) * PW'(f_mag);
        rhs     = {g_mag, {RW{1'b0}}};
        lhs_neg = f_neg && (random_word != '0);

        case ({lhs_neg, g_neg})
            2'b00:   slow_rej = lhs > rhs;
            2'b10:   slow_rej = 1'b1;
            2'b01:   slow_rej = 1'b0;
            2'b11:   slow_rej = lhs < rhs;
            default: slow_rej = 1'b0;
        endcase

        verdict.used   = !fast && !outright;
        verdict.reject = outright || (!fast && slow_rej);
    end

endmodule

/* sv/coeff_rejection_test_top.sv */
// top level of the per-coefficient rejection test with stream ports and config channel
// an input transfer goes through the input register and the result register to m_tdata
// throughput: one coefficient per cycle while m_tready does not stall, limited by the
// single 24x18 multiply and compare between the input and result registers
// reset: aresetn synchronous active low, clears both stage valids and the running
// reject flag and loads gamma bound 2048 and beta margin 1
module coeff_rejection_test_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [crt_pkg::IW-1:0]         cfg_index,
    input  logic [crt_pkg::CDW-1:0]        cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // z_coeff[15:0], v_coeff[31:16], random_word[55:32]
    input  logic [crt_pkg::S_TDATA_W-1:0]  s_tdata,
    // first_of_poly[0]
    input  logic                           s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // random_used[0], coeff_reject[1], reject_so_far[2], zero pad [7:3]
    output logic [crt_pkg::M_TDATA_W-1:0]  m_tdata
);

    // configuration registers
    logic [crt_pkg::GW-1:0] gamma_reg;
    logic [crt_pkg::BW-1:0] beta_reg;

    // input stage
    logic                          in_valid_reg;
    logic signed [crt_pkg::ZW-1:0] z_reg, v_reg;
    logic [crt_pkg::RW-1:0]        rnd_reg;
    logic                          first_reg;

    // result stage
    logic       out_valid_reg;
    logic       used_reg, rej_reg, so_far_reg;
    logic       accum_reg, accum_next;

    crt_pkg::crt_verdict_t verdict;
    logic       out_adv, in_take;

    assign cfg_ready = 1'b1;

    // result stage can load when empty or when its transfer completes
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign in_take  = s_tvalid && s_tready;

    crt_verdict u_verdict (
        .z_coeff     (z_reg),
        .v_coeff     (v_reg),
        .random_word (rnd_reg),
        .gamma_bound (gamma_reg),
        .beta_margin (beta_reg),
        .verdict     (verdict)
    );

    // running flag restarts on the first coefficient of a polynomial
    assign accum_next = (first_reg ? 1'b0 : accum_reg) | verdict.reject;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= crt_pkg::GAMMA_RESET;
            beta_reg  <= crt_pkg::BETA_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                crt_pkg::REG_GAMMA_BOUND: gamma_reg <= cfg_data[crt_pkg::GW-1:0];
                crt_pkg::REG_BETA_MARGIN: beta_reg  <= cfg_data[crt_pkg::BW-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            z_reg     <= s_tdata[15:0];
            v_reg     <= s_tdata[31:16];
            rnd_reg   <= s_tdata[55:32];
            first_reg <= s_tuser;
        end
    end

    // result register and running reject flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            accum_reg     <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                accum_reg <= accum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            used_reg   <= verdict.used;
            rej_reg    <= verdict.reject;
            so_far_reg <= accum_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, so_far_reg, rej_reg, used_reg};

endmodule

/* tb/sv/tb_coeff_rejection_test_top.sv */
// self-checking testbench of the per-coefficient rejection test block
module tb_coeff_rejection_test_top;

    localparam int ZW        = crt_pkg::ZW;
    localparam int RW        = crt_pkg::RW;
    localparam int GW        = crt_pkg::GW;
    localparam int BW        = crt_pkg::BW;
    localparam int CDW       = crt_pkg::CDW;
    localparam int S_TDATA_W = crt_pkg::S_TDATA_W;
    localparam int M_TDATA_W = crt_pkg::M_TDATA_W;

    typedef longint unsigned u64_t;

    // one coefficient as it travels on the input stream
    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic signed [ZW-1:0] v;
        logic [RW-1:0]        r;
        logic                 first;
    } coeff_item_t;

    // one verdict as it comes back on the result stream
    typedef struct packed {
        logic used;
        logic reject;
        logic so_far;
    } verdict_t;

    localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
    localparam int LONG_HOLD       = 300;   // receiver hold-off for the back-pressure phase
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int PRESSURE_PHASE  = 3;
    localparam int DRAIN_CYCLES    = 4;     // block holds an input register and a result register

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    crt_pkg::cfg_idx_t cfg_index = crt_pkg::REG_GAMMA_BOUND;
    logic [CDW-1:0]    cfg_data = '0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // z_coeff[15:0], v_coeff[31:16], random_word[55:32]
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0; // first_of_poly[0]

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // random_used[0], coeff_reject[1], reject_so_far[2]

    coeff_rejection_test_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // shared state between stimulus, driver and monitor
    // ------------------------------------------------------------------
    coeff_item_t coeff_queue[$];    // coefficients waiting to be offered
    verdict_t    verdict_queue[$];  // verdicts predicted for accepted coefficients

    // predictor copy of the config registers and the running reject flag
    logic [GW-1:0] gamma_now = crt_pkg::GAMMA_RESET;
    logic [BW-1:0] beta_now  = crt_pkg::BETA_RESET;
    logic          poly_reject = 1'b0;

    int  mismatch_count = 0;
    int  hold_requests  = 0;    // bumped by the stimulus to ask for a long hold-off
    bit  src_burst = 1'b0;      // no gaps on the sender side
    bit  snk_burst = 1'b0;      // no stalls on the receiver side

    function automatic longint max_l(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // random idle length: mostly zero, sometimes short, rarely long
    function automatic int pick_gap(bit burst);
        int n;
        if (burst)
            return 0;
        n = int'($urandom_range(0, 99));
        if (n < 60)
            return 0;
        if (n < 88)
            return int'($urandom_range(1, 3));
        if (n < 97)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 40));
    endfunction

    // expected verdict of one coefficient; updates the running reject flag
    function automatic verdict_t judge_coeff(coeff_item_t it);
        longint   zs, vs, mag, vb, g1, b2, f, g;
        u64_t     lhs, rhs;
        verdict_t res;
        zs  = longint'($signed(it.z));
        vs  = longint'($signed(it.v));
        mag = (zs < 0) ? -zs : zs;
        vb  = (vs < 0) ? -vs : vs;
        g1  = longint'(gamma_now);
        b2  = longint'(beta_now);
        res = '0;
        if (it.first)
            poly_reject = 1'b0;
        // the fast-accept window lies below gamma, so the outright reject goes first
        if (mag >= g1) begin
            res.reject = 1'b1;
        end else if (mag < b2 || mag >= g1 - b2) begin
            res.used = 1'b1;
            if (mag < b2) begin
                f = 2 * g1 - 2 * max_l(mag, vb);
                g = 2 * (g1 - b2);
            end else begin
                f = max_l(g1 - ((mag > vb) ? mag - vb : vb - mag), 0)
                    + max_l(g1 - (mag + vb), 0);
                g = 2 * max_l(g1 - max_l(mag, b2), 0);
            end
            // negative terms wrap as 64-bit words, compare is unsigned
            lhs = u64_t'(it.r) * u64_t'(f);
            rhs = u64_t'(g) << 24;
            if (lhs > rhs)
                res.reject = 1'b1;
        end
        if (res.reject)
            poly_reject = 1'b1;
        res.so_far = poly_reject;
        return res;
    endfunction

    // random coefficient aimed mostly at the edges of the current windows
    function automatic coeff_item_t random_coeff();
        coeff_item_t it;
        longint g1, b2, mag, vm, lo;
        g1 = longint'(gamma_now);
        b2 = longint'(beta_now);
        case ($urandom_range(0, 9))
            0, 1, 2: mag = longint'($urandom_range(0, int'(b2) + 1));
            3, 4, 5: begin
                lo  = max_l(g1 - b2 - 2, 0);
                mag = lo + longint'($urandom_range(0, int'(g1 + 1 - lo)));
            end
            6:       mag = longint'($urandom_range(0, int'(g1 + b2) + 2));
            default: mag = -1;
        endcase
        if (mag < 0) begin
            it.z = ZW'($urandom());
        end else begin
            if (mag > 32768)
                mag = 32768;
            it.z = ZW'($urandom_range(0, 1) ? -mag : mag);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                vm = ((mag < 0) ? g1 : mag)
                     + longint'($urandom_range(0, 2 * int'(b2) + 4)) - (b2 + 2);
                vm = (vm < 0) ? 0 : ((vm > 32768) ? 32768 : vm);
                it.v = ZW'($urandom_range(0, 1) ? -vm : vm);
            end
            4, 5: begin
                vm   = longint'($urandom_range(0, int'(g1 + b2) + 4));
                vm   = (vm > 32768) ? 32768 : vm;
                it.v = ZW'($urandom_range(0, 1) ? -vm : vm);
            end
            6: begin
                vm   = longint'($urandom_range(0, 16));
                it.v = ZW'($urandom_range(0, 1) ? -vm : vm);
            end
            default: it.v = ZW'($urandom());
        endcase
        case ($urandom_range(0, 9))
            0:       it.r = '0;
            1:       it.r = '1;
            default: it.r = RW'($urandom());
        endcase
        // polynomials of random length
        it.first = ($urandom_range(0, 11) == 0);
        return it;
    endfunction

    function automatic void push_coeff(int z, int v, int r, bit first);
        coeff_item_t it;
        it.z     = ZW'(z);
        it.v     = ZW'(v);
        it.r     = RW'(r);
        it.first = first;
        coeff_queue.push_back(it);
    endfunction

    task automatic flag_error(string msg);
        if (mismatch_count < 10)
            $display("%s", msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // input driver: offers queued coefficients, predicts on each transfer
    // ------------------------------------------------------------------
    coeff_item_t on_bus;
    int          src_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  = 0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_queue.push_back(judge_coeff(on_bus));
            // the bus is free once the current item has gone or none was offered
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (coeff_queue.size() > 0) begin
                    on_bus   = coeff_queue.pop_front();
                    s_tdata  <= {on_bus.r, on_bus.v, on_bus.z};
                    s_tuser  <= on_bus.first;
                    s_tvalid <= 1'b1;
                    src_gap  = pick_gap(src_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, compares each transfer
    // ------------------------------------------------------------------
    int stall_left = 0;
    int hold_served = 0;

    always @(posedge aclk) begin
        verdict_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.used   = m_tdata[0];
                got.reject = m_tdata[1];
                got.so_far = m_tdata[2];
                if (verdict_queue.size() == 0) begin
                    flag_error($sformatf("unexpected result used=%0d reject=%0d so_far=%0d",
                                         got.used, got.reject, got.so_far));
                end else begin
                    want = verdict_queue.pop_front();
                    if (got != want)
                        flag_error($sformatf(
                            {"result mismatch: expected used=%0d reject=%0d so_far=%0d, ",
                             "got used=%0d reject=%0d so_far=%0d"},
                            want.used, want.reject, want.so_far,
                            got.used, got.reject, got.so_far));
                end
            end
            if (hold_served != hold_requests) begin
                // long hold-off so the pipeline fills and the input stalls
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(snk_burst);
                if (stall_left == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no transfer happens for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // register write on the config channel, predictor copy follows
    task automatic write_reg(crt_pkg::cfg_idx_t idx, int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CDW'(value);
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == crt_pkg::REG_GAMMA_BOUND)
            gamma_now = GW'(value);
        else if (idx == crt_pkg::REG_BETA_MARGIN)
            beta_now = BW'(value);
    endtask

    // all coefficients sent, all verdicts back, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (coeff_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int gamma_tab[8];
        int beta_tab[8];
        int gam, bet;

        // corner settings first, random ones after
        gamma_tab = '{1, 8192, 8192, 0, 300, 100, 4096, 2};
        beta_tab  = '{0, 8191, 0,    0, 500, 49,  2000, 1};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed coefficients under the reset setting (gamma 2048, beta 1)
        @(negedge aclk);
        push_coeff(0, 0, 0, 1);                  // below beta, slope test passes
        push_coeff(0, 0, 'hFFFFFF, 0);           // same with largest word
        push_coeff(1, 0, 'h123456, 0);           // lower edge of fast-accept window
        push_coeff(2046, -5, 'h654321, 0);       // upper edge of fast-accept window
        push_coeff(2047, 2047, 'hFFFFFF, 0);     // just above the window
        push_coeff(-2047, -32768, 0, 0);         // v far above gamma, f clamps to zero
        push_coeff(2048, 0, 0, 0);               // at gamma, outright reject
        push_coeff(-2048, 7, 'hFFFFFF, 0);
        push_coeff(32767, 32767, 'hFFFFFF, 1);   // largest magnitudes
        push_coeff(-32767, -32767, 0, 0);
        push_coeff(-32768, 0, 0, 0);             // most negative z
        push_coeff(0, 32767, 'hFFFFFF, 0);       // negative f wraps
        push_coeff(0, -32768, 1, 0);
        push_coeff(1000, 'h5555, 'hAAAAAA, 1);
        push_coeff(-1000, 'hAAAA, 'h555555, 0);
        push_coeff(2047, 0, 'h800000, 1);
        push_coeff(-2047, 2000, 'h7FFFFF, 0);
        push_coeff(0, 1, 'hFFFFFF, 1);
        push_coeff(2047, 1, 'hFFFFFF, 0);
        push_coeff(-1, 'h8000, 'hFFFFFF, 0);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 8) begin
                gam = gamma_tab[ph];
                bet = beta_tab[ph];
            end else begin
                gam = int'($urandom_range(1, 8192));
                bet = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8191))
                                                  : int'($urandom_range(0, gam - 1));
            end
            write_reg(crt_pkg::REG_GAMMA_BOUND, gam);
            write_reg(crt_pkg::REG_BETA_MARGIN, bet);
            @(negedge aclk);
            src_burst = ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            if (ph == PRESSURE_PHASE) begin
                // sender keeps offering while the receiver holds off
                src_burst = 1'b1;
                hold_requests++;
            end
            repeat (ITEMS_PER_PHASE) coeff_queue.push_back(random_coeff());
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        mismatch_count += verdict_queue.size();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
